[src/prm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prm_pkg: shared types and constants for the prefix rule match/rewrite block
// Item and result structs, rule record layouts, command, family and action
// codes, and the prefix mask helper.
// ----------------------------------------------------------------------------
package prm_pkg;

    localparam int MAX_RULES_DEF = 16;
    localparam int CFG_W         = 5;
    localparam int SLOT_W        = 4;
    localparam int V4_PFX_MAX    = 32;

    localparam logic [1:0] CMD_CLASSIFY = 2'd0;
    localparam logic [1:0] CMD_WR_MATCH = 2'd1;
    localparam logic [1:0] CMD_WR_REPL  = 2'd2;

    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    localparam logic [1:0] ACT_PASS       = 2'd0;
    localparam logic [1:0] ACT_REWRITE    = 2'd1;
    localparam logic [1:0] ACT_DENY       = 2'd2;
    localparam logic [1:0] ACT_WRITE_DONE = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [SLOT_W-1:0] rule_slot;
        logic [1:0]        family;
        logic [63:0]       address_high;
        logic [63:0]       address_low;
        logic [15:0]       port;
        logic [7:0]        prefix_length;
        logic              entry_present;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        action;
        logic [1:0]        out_family;
        logic [63:0]       out_address_high;
        logic [63:0]       out_address_low;
        logic [15:0]       out_port;
        logic [SLOT_W-1:0] hit_slot;
        logic              hit;
    } t_out_item;

    typedef struct packed {
        logic        present;
        logic [1:0]  family;
        logic [15:0] port;
        logic [7:0]  prefix_len;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_match_rec;

    typedef struct packed {
        logic        present;
        logic [1:0]  family;
        logic [15:0] port;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_repl_rec;

    function automatic logic [127:0] lead_mask128(input logic [7:0] p);
        logic [127:0] m;
        for (int i = 0; i < 128; i++) begin
            m[127 - i] = (i < int'(p));
        end
        return m;
    endfunction

    function automatic t_out_item echo_item(input t_in_item it);
        t_out_item r;
        r                  = '0;
        r.action           = ACT_PASS;
        r.out_family       = it.family;
        r.out_address_high = it.address_high;
        r.out_address_low  = it.address_low;
        r.out_port         = it.port;
        return r;
    endfunction

endpackage
`default_nettype wire

[src/prm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[src/prm_rule_eval.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prm_rule_eval: single rule check and rewrite
// Decides whether one rule matches the held address and forms the rewritten
// or denied result for it.
// ----------------------------------------------------------------------------
module prm_rule_eval (
    input  wire prm_pkg::t_in_item   i_item,
    input  wire prm_pkg::t_match_rec i_match,
    input  wire prm_pkg::t_repl_rec  i_repl,
    output logic                     o_match,
    output prm_pkg::t_out_item       o_res
);
    import prm_pkg::*;

    logic [127:0] in_key;
    logic [127:0] rule_key;
    logic [127:0] mask;
    logic [7:0]   pfx_eff;
    logic         key_eq;
    logic         is_ip;
    logic         port_ok;
    logic         repl_fam_ok;

    always_comb begin
        if (i_item.family == FAM_V4) begin
            in_key   = {i_item.address_low[31:0], 96'b0};
            rule_key = {i_match.addr_low[31:0], 96'b0};
            pfx_eff  = (i_match.prefix_len > 8'(V4_PFX_MAX)) ?
                       8'(V4_PFX_MAX) : i_match.prefix_len;
        end else begin
            in_key   = {i_item.address_high, i_item.address_low};
            rule_key = {i_match.addr_high, i_match.addr_low};
            pfx_eff  = i_match.prefix_len;
        end
        mask = lead_mask128(pfx_eff);
    end

    assign key_eq      = ((in_key ^ rule_key) & mask) == '0;
    assign is_ip       = (i_item.family == FAM_V4) || (i_item.family == FAM_V6);
    assign port_ok     = (i_match.port == 16'd0) || (i_match.port == i_item.port);
    assign repl_fam_ok = !i_repl.present || (i_repl.family == i_item.family);

    always_comb begin
        if (!i_match.present) begin
            o_match = repl_fam_ok;
        end else begin
            o_match = repl_fam_ok && (i_match.family == i_item.family) && is_ip &&
                      port_ok && key_eq;
        end
    end

    always_comb begin
        o_res     = echo_item(i_item);
        o_res.hit = 1'b1;
        if (i_repl.present) begin
            o_res.action     = ACT_REWRITE;
            o_res.out_family = i_repl.family;
            if (i_item.family == FAM_V4) begin
                o_res.out_address_high = 64'd0;
                o_res.out_address_low  = {32'd0, i_repl.addr_low[31:0]};
            end else begin
                o_res.out_address_high = i_repl.addr_high;
                o_res.out_address_low  = i_repl.addr_low;
            end
            o_res.out_port = (i_repl.port != 16'd0) ? i_repl.port : i_item.port;
        end else begin
            o_res.action = ACT_DENY;
        end
    end

endmodule
`default_nettype wire

[src/prefix_rule_match_rewrite.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_rule_match_rewrite: first-match IP prefix rule table with rewrite
// Timing: a rule write's result passes through the result register and then
//   the output register; a lookup reads the active rules one rule per cycle from
//   the rule memories' read port, and the first match ends the scan.
// Throughput: one item at a time; the next item is taken once the previous
//   result has entered the output register.
// Reset: synchronous, active low; clears control and rule_count. Rule
//   memories are not cleared.
// ----------------------------------------------------------------------------
module prefix_rule_match_rewrite #(
    parameter int MAX_RULES = prm_pkg::MAX_RULES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [prm_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire prm_pkg::t_in_item        i_in,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output prm_pkg::t_out_item            o_out
);
    import prm_pkg::*;

    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W = $clog2(MAX_RULES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CFG_W-1:0] r_cfg;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic             r_out_valid, n_out_valid;
    t_in_item         r_item, n_item;
    t_out_item        r_res, n_res;
    t_out_item        r_out, n_out;

    logic             in_acc;
    logic             out_free;
    logic [CNT_W-1:0] cnt_sat;
    logic             slot_ok;
    logic [31:0]      slot_ext;
    logic [31:0]      pend_ext;
    logic             is_wr_match;
    logic             is_wr_repl;
    logic             is_write;
    logic             issue;
    logic             last;

    t_match_rec       match_wdata, match_q;
    t_repl_rec        repl_wdata, repl_q;
    t_out_item        eval_res;
    logic             eval_match;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign cnt_sat  = (32'(r_cfg) > 32'(MAX_RULES)) ? CNT_W'(MAX_RULES) : CNT_W'(r_cfg);
    assign slot_ext = 32'(i_in.rule_slot);
    assign slot_ok  = slot_ext < 32'(MAX_RULES);
    assign pend_ext = 32'(r_pend_idx);

    assign is_wr_match = (i_in.cmd == CMD_WR_MATCH);
    assign is_wr_repl  = (i_in.cmd == CMD_WR_REPL);
    assign is_write    = is_wr_match || is_wr_repl;

    assign issue = (r_state == S_SCAN) && (r_rd_idx < r_n);
    assign last  = (CNT_W'(r_pend_idx) + CNT_W'(1)) == r_n;

    always_comb begin
        match_wdata.present    = i_in.entry_present;
        match_wdata.family     = i_in.family;
        match_wdata.port       = i_in.port;
        match_wdata.prefix_len = i_in.prefix_length;
        match_wdata.addr_high  = i_in.address_high;
        match_wdata.addr_low   = i_in.address_low;
        repl_wdata.present     = i_in.entry_present;
        repl_wdata.family      = i_in.family;
        repl_wdata.port        = i_in.port;
        repl_wdata.addr_high   = i_in.address_high;
        repl_wdata.addr_low    = i_in.address_low;
    end

    prm_ram #(
        .WIDTH ($bits(t_match_rec)),
        .DEPTH (MAX_RULES),
        .AW    (IDX_W)
    ) u_match_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && is_wr_match && slot_ok),
        .i_waddr (slot_ext[IDX_W-1:0]),
        .i_wdata (match_wdata),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (match_q)
    );

    prm_ram #(
        .WIDTH ($bits(t_repl_rec)),
        .DEPTH (MAX_RULES),
        .AW    (IDX_W)
    ) u_repl_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && is_wr_repl && slot_ok),
        .i_waddr (slot_ext[IDX_W-1:0]),
        .i_wdata (repl_wdata),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (repl_q)
    );

    prm_rule_eval u_eval (
        .i_item  (r_item),
        .i_match (match_q),
        .i_repl  (repl_q),
        .o_match (eval_match),
        .o_res   (eval_res)
    );

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_out_valid = r_out_valid;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_item   = i_in;
                    n_res    = echo_item(i_in);
                    n_n      = cnt_sat;
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    n_state  = S_DONE;
                    if (is_write) begin
                        n_res        = '0;
                        n_res.action = ACT_WRITE_DONE;
                    end else if ((i_in.cmd == CMD_CLASSIFY) &&
                                 ((i_in.family == FAM_V4) || (i_in.family == FAM_V6)) &&
                                 (cnt_sat != '0)) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_pend = issue;
                if (issue) begin
                    n_pend_idx = r_rd_idx[IDX_W-1:0];
                    n_rd_idx   = r_rd_idx + CNT_W'(1);
                end
                if (r_pend) begin
                    if (eval_match) begin
                        n_res          = eval_res;
                        n_res.hit_slot = pend_ext[SLOT_W-1:0];
                        n_state        = S_DONE;
                    end else if (last) begin
                        n_res   = echo_item(r_item);
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_rd_idx    <= '0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_n         <= n_n;
            r_rd_idx    <= n_rd_idx;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_item     <= n_item;
        r_res      <= n_res;
        r_out      <= n_out;
    end

endmodule
`default_nettype wire

[src/prm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prm_checker: port-level assertions for prefix_rule_match_rewrite
// Watches the handshakes and the result encoding; bound to the top level.
// ----------------------------------------------------------------------------
module prm_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_ready,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire prm_pkg::t_out_item        o_out
);
    import prm_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    a_hit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.hit == ((o_out.action == ACT_REWRITE) ||
                                       (o_out.action == ACT_DENY))))
        else $error("hit flag disagrees with action");

    a_write_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.action == ACT_WRITE_DONE) |->
            (o_out.out_address_high == 64'd0) && (o_out.out_address_low == 64'd0) &&
            (o_out.out_port == 16'd0) && (o_out.hit_slot == '0) &&
            (o_out.out_family == 2'd0))
        else $error("rule write result not cleared");

endmodule

bind prefix_rule_match_rewrite prm_checker u_prm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire
